// ===== design/pcxrld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxrld_pkg
// Shared types and constants for the PCX run-length line decoder.
// ----------------------------------------------------------------------------
package pcxrld_pkg;

    localparam int LEN_W     = 14;   // line length, column and line counters
    localparam int BYTE_W    = 8;
    localparam int RUN_W     = 6;    // run count / run length
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0]  MAX_LINE_BYTES = LEN_W'(8192);
    localparam logic [1:0]        RUN_MARK       = 2'b11;   // top bits of a run header

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_BYTES    = 2'd0,
        CFG_VISIBLE_BYTES = 2'd1,
        CFG_LINE_TOTAL    = 2'd2
    } cfg_idx_t;

    // one result transaction
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [RUN_W-1:0]  length;
        logic              padding;
        logic              line_done;
        logic              image_done;
        logic              last;
    } run_res_t;

endpackage

// ===== design/pcx_rle_line_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder_top
// PCX run-length decoder: compressed bytes in, clipped and padded runs out.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ---------------------------------------------
//  in       in_valid / in_stall    code_byte, image_start
//  out      out_valid / out_stall  run_value, run_length, is_padding, line_done,
//                                  image_done, last_of_item
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (write only)
//
//  One input byte is decoded in the cycle it is accepted; its zero, one or two
//  results land in a two-entry output queue and show up the next cycle.
//  A byte is taken when the queue is empty, or holds one result that leaves in
//  the same cycle: one-result bytes stream at one per clock while out_stall is
//  low; a two-result byte (visible run plus line-end padding) stalls input.
//  Reset clears decode state and the queue, registers come up at 1; cfg_ready
//  is tied high; write the port only while the block is idle (unenforced).
// ----------------------------------------------------------------------------
module pcx_rle_line_decoder_top (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [pcxrld_pkg::BYTE_W-1:0]          code_byte,
    input  logic                                   image_start,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [pcxrld_pkg::BYTE_W-1:0]          run_value,
    output logic [pcxrld_pkg::RUN_W-1:0]           run_length,
    output logic                                   is_padding,
    output logic                                   line_done,
    output logic                                   image_done,
    output logic                                   last_of_item,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pcxrld_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pcxrld_pkg::LEN_W-1:0]           cfg_data
);
    import pcxrld_pkg::*;

    // ---------------------------------------------------------------- config
    logic [LEN_W-1:0] line_bytes_reg;
    logic [LEN_W-1:0] visible_bytes_reg;
    logic [LEN_W-1:0] line_total_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_bytes_reg    <= LEN_W'(1);
            visible_bytes_reg <= LEN_W'(1);
            line_total_reg    <= LEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LINE_BYTES:    line_bytes_reg    <= cfg_data;
                CFG_VISIBLE_BYTES: visible_bytes_reg <= cfg_data;
                CFG_LINE_TOTAL:    line_total_reg    <= cfg_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // Effective lengths: zero acts as one, line lengths saturate at the max,
    // and the visible width never exceeds the line.
    logic [LEN_W-1:0] lb_eff;
    logic [LEN_W-1:0] vis_raw;
    logic [LEN_W-1:0] vis_eff;
    logic [LEN_W-1:0] lt_eff;

    always_comb
    begin
        if (line_bytes_reg == '0)
            lb_eff = LEN_W'(1);
        else if (line_bytes_reg > MAX_LINE_BYTES)
            lb_eff = MAX_LINE_BYTES;
        else
            lb_eff = line_bytes_reg;

        if (visible_bytes_reg == '0)
            vis_raw = LEN_W'(1);
        else if (visible_bytes_reg > MAX_LINE_BYTES)
            vis_raw = MAX_LINE_BYTES;
        else
            vis_raw = visible_bytes_reg;

        vis_eff = (vis_raw > lb_eff) ? lb_eff : vis_raw;
        lt_eff  = (line_total_reg == '0) ? LEN_W'(1) : line_total_reg;
    end

    // ---------------------------------------------------------- decode state
    logic              await_value_reg, await_value_next;
    logic [RUN_W-1:0]  pending_reg,     pending_next;
    logic [LEN_W-1:0]  column_reg,      column_next;
    logic [LEN_W-1:0]  line_index_reg,  line_index_next;
    logic              finished_reg,    finished_next;

    // output queue, slot 0 is the head
    run_res_t          slot0_reg, slot0_next;
    run_res_t          slot1_reg, slot1_next;
    logic [1:0]        count_reg, count_next;

    logic in_take;
    logic out_pop;

    assign out_pop  = out_valid && !out_stall;
    assign in_stall = !((count_reg == 2'd0) || ((count_reg == 2'd1) && out_pop));
    assign in_take  = in_valid && !in_stall;

    // start-of-image clears position before the byte is taken
    logic              aw_cur;
    logic [RUN_W-1:0]  pend_cur;
    logic [LEN_W-1:0]  col_cur;
    logic [LEN_W-1:0]  lidx_cur;
    logic              fin_cur;

    assign aw_cur   = image_start ? 1'b0 : await_value_reg;
    assign pend_cur = image_start ? '0   : pending_reg;
    assign col_cur  = image_start ? '0   : column_reg;
    assign lidx_cur = image_start ? '0   : line_index_reg;
    assign fin_cur  = image_start ? 1'b0 : finished_reg;

    logic              is_header;
    logic              decode_run;    // a byte that carries pixel data
    logic [RUN_W-1:0]  run_n;
    logic [LEN_W-1:0]  remain;
    logic [RUN_W-1:0]  take;
    logic [LEN_W-1:0]  vis_gap;
    logic [RUN_W-1:0]  vis_len;
    logic [LEN_W-1:0]  col_sum;
    logic              line_end;
    logic [1:0]        pad_len;
    logic [LEN_W-1:0]  lidx_inc;
    logic              img_end;
    logic              has_vis;
    logic              has_tail;
    logic [1:0]        n_new;
    run_res_t          res_vis;
    run_res_t          res_tail;
    run_res_t          push0;
    run_res_t          push1;

    always_comb
    begin
        is_header  = !aw_cur && (code_byte[BYTE_W-1 -: 2] == RUN_MARK);
        run_n      = aw_cur ? pend_cur : RUN_W'(1);
        decode_run = !fin_cur && !is_header && (run_n != '0);

        // clip to the rest of the line
        remain  = (col_cur < lb_eff) ? (lb_eff - col_cur) : LEN_W'(1);
        take    = ({{(LEN_W-RUN_W){1'b0}}, run_n} < remain) ? run_n : remain[RUN_W-1:0];

        // and to the visible part
        vis_gap = vis_eff - col_cur;
        if (col_cur < vis_eff)
            vis_len = (vis_gap < {{(LEN_W-RUN_W){1'b0}}, take}) ? vis_gap[RUN_W-1:0] : take;
        else
            vis_len = '0;

        col_sum  = col_cur + {{(LEN_W-RUN_W){1'b0}}, take};
        line_end = decode_run && (col_sum >= lb_eff);
        pad_len  = 2'd0 - vis_eff[1:0];
        lidx_inc = lidx_cur + LEN_W'(1);
        img_end  = line_end && (lidx_inc >= lt_eff);

        has_vis  = decode_run && (vis_len != '0);
        // padding, or a bare end marker when nothing else marks the line end
        has_tail = line_end && ((pad_len != 2'd0) || !has_vis);

        res_vis.value      = code_byte;
        res_vis.length     = vis_len;
        res_vis.padding    = 1'b0;
        res_vis.line_done  = line_end && !has_tail;
        res_vis.image_done = img_end && !has_tail;
        res_vis.last       = !has_tail;

        res_tail.value      = '0;
        res_tail.length     = {{(RUN_W-2){1'b0}}, pad_len};
        res_tail.padding    = (pad_len != 2'd0);
        res_tail.line_done  = 1'b1;
        res_tail.image_done = img_end;
        res_tail.last       = 1'b1;

        push0 = has_vis ? res_vis : res_tail;
        push1 = res_tail;
        n_new = {1'b0, has_vis} + {1'b0, has_tail};
    end

    // next decode state
    always_comb
    begin
        await_value_next = await_value_reg;
        pending_next     = pending_reg;
        column_next      = column_reg;
        line_index_next  = line_index_reg;
        finished_next    = finished_reg;

        if (in_take)
        begin
            await_value_next = aw_cur;
            pending_next     = pend_cur;
            column_next      = col_cur;
            line_index_next  = lidx_cur;
            finished_next    = fin_cur;

            if (!fin_cur)
            begin
                if (is_header)
                begin
                    await_value_next = 1'b1;
                    pending_next     = code_byte[RUN_W-1:0];
                end
                else
                begin
                    await_value_next = 1'b0;
                    pending_next     = '0;
                    if (decode_run)
                    begin
                        if (line_end)
                        begin
                            column_next     = '0;
                            line_index_next = lidx_inc;
                            finished_next   = img_end;
                        end
                        else
                        begin
                            column_next = col_sum;
                        end
                    end
                end
            end
        end
    end

    // output queue update
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;

        if (out_pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end

        if (in_take && (n_new != 2'd0))
        begin
            if (count_next == 2'd0)
            begin
                slot0_next = push0;
                slot1_next = push1;
            end
            else
            begin
                slot1_next = push0;
            end
            count_next = count_next + n_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            await_value_reg <= 1'b0;
            pending_reg     <= '0;
            column_reg      <= '0;
            line_index_reg  <= '0;
            finished_reg    <= 1'b0;
            count_reg       <= 2'd0;
        end
        else
        begin
            await_value_reg <= await_value_next;
            pending_reg     <= pending_next;
            column_reg      <= column_next;
            line_index_reg  <= line_index_next;
            finished_reg    <= finished_next;
            count_reg       <= count_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign out_valid    = (count_reg != 2'd0);
    assign run_value    = slot0_reg.value;
    assign run_length   = slot0_reg.length;
    assign is_padding   = slot0_reg.padding;
    assign line_done    = slot0_reg.line_done;
    assign image_done   = slot0_reg.image_done;
    assign last_of_item = slot0_reg.last;

`ifndef SYNTHESIS
    // queue never overfills
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output queue count out of range");

    // a non-final result always has its partner queued right behind it
    a_pair_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !slot0_reg.last) |-> (count_reg == 2'd2))
        else $error("first result of a pair without its partner");

    // column stays inside the longest line
    a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg < MAX_LINE_BYTES)
        else $error("column beyond maximum line length");

    // an image only finishes after at least one line
    a_finish_lines: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> (line_index_reg != '0))
        else $error("image finished with no line done");

    // a pending run header never survives into the finished state
    a_no_await_done: assert property (@(posedge clk) disable iff (!rst_n)
        await_value_reg |-> !finished_reg)
        else $error("awaiting run value after image end");
`endif

endmodule
